/* hw/rtl/qmgs_pkg.sv */
// ----------------------------------------------------------------------------
// QR MGS package
// Shared sizes, codes, state machine and command types, and the saturating helper of the QR factoriser.
// ----------------------------------------------------------------------------
`default_nettype none

package qmgs_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int MAX_COLS  = 16;

    localparam int ELEM_W    = 32;
    localparam int IDX_W     = 4;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 5;

    localparam int ROW_CW    = $clog2(MAX_ROWS + 1);
    localparam int COL_CW    = $clog2(MAX_COLS + 1);
    localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);
    localparam int TRI_DEPTH = MAX_COLS * MAX_COLS;
    localparam int TRI_AW    = $clog2(TRI_DEPTH);

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 48;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_FACT  = 2'd1,
        REQ_RD_Q  = 2'd2,
        REQ_RD_R  = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_NORM = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_RESP, S_COL,
        S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_R_WR,
        S_UPD_RD, S_UPD_MUL, S_UPD_WR,
        S_NRM_RD, S_NRM_MUL, S_NRM_ACC, S_SQRT, S_DIAG,
        S_ZERO_WR, S_SCL_RD, S_DIV_LD, S_DIV, S_SCL_WR
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD_REQ, OP_ELEM, OP_RESP, OP_FACT_START,
        OP_DOT_RD, OP_DOT_MUL, OP_DOT_ACC, OP_R_WR,
        OP_UPD_RD, OP_UPD_MUL, OP_UPD_WR,
        OP_NRM_RD, OP_NRM_MUL, OP_NRM_ACC, OP_SQ_STEP, OP_DIAG_WR,
        OP_ZERO_WR, OP_SCL_RD, OP_DIV_LD, OP_DIV_STEP, OP_SCL_WR
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [ROW_CW-1:0]   k;
        logic [COL_CW-1:0]   i;
        logic [COL_CW-1:0]   j;
        logic                first;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic req_is_fact;
        logic nrm_zero;
    } t_dp_stat;

    function automatic logic signed [ELEM_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [ELEM_W-1:0] y;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[ELEM_W-1:0];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/qmgs_req_if.sv */
// ----------------------------------------------------------------------------
// QR MGS request channel
// Valid/ready channel carrying one element write, factorise or read request.
// ----------------------------------------------------------------------------
`default_nettype none

interface qmgs_req_if;
    logic                                    valid;
    logic                                    ready;
    logic [qmgs_pkg::REQ_W-1:0]              req_type;
    logic [qmgs_pkg::IDX_W-1:0]              row_index;
    logic [qmgs_pkg::IDX_W-1:0]              col_index;
    logic signed [qmgs_pkg::ELEM_W-1:0]      elem_value;

    modport source (output valid, req_type, row_index, col_index, elem_value,
                    input ready);
    modport sink   (input valid, req_type, row_index, col_index, elem_value,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/qmgs_rsp_if.sv */
// ----------------------------------------------------------------------------
// QR MGS response channel
// Valid/ready channel carrying the read value and status of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface qmgs_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [qmgs_pkg::ELEM_W-1:0]      read_value;
    logic [qmgs_pkg::STAT_W-1:0]             status_code;

    modport source (output valid, read_value, status_code, input ready);
    modport sink   (input valid, read_value, status_code, output ready);
endinterface

`default_nettype wire

/* hw/rtl/qmgs_ctrl.sv */
// ----------------------------------------------------------------------------
// QR MGS controller
// Sequences request handling and the column / projection / row loops.
// ----------------------------------------------------------------------------
`default_nettype none

module qmgs_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire logic [qmgs_pkg::ROW_CW-1:0]   i_m,
    input  wire logic [qmgs_pkg::COL_CW-1:0]   i_n,
    input  wire qmgs_pkg::t_dp_stat            i_stat,
    output qmgs_pkg::t_dp_cmd                  o_cmd
);

    qmgs_pkg::t_state                   r_state, n_state;
    logic [qmgs_pkg::ROW_CW-1:0]        r_k, n_k;
    logic [qmgs_pkg::COL_CW-1:0]        r_i, n_i;
    logic [qmgs_pkg::COL_CW-1:0]        r_j, n_j;
    logic [qmgs_pkg::STEP_W-1:0]        r_step, n_step;

    logic req_acc, last_k, last_i, last_sq, last_div, cols_done;

    assign req_acc   = i_req_valid && o_req_ready;
    assign last_k    = (r_k + qmgs_pkg::ROW_CW'(1)) == i_m;
    assign last_i    = (r_i + qmgs_pkg::COL_CW'(1)) == r_j;
    assign last_sq   = r_step == qmgs_pkg::STEP_W'(qmgs_pkg::SQRT_STEPS - 1);
    assign last_div  = r_step == qmgs_pkg::STEP_W'(qmgs_pkg::DIV_STEPS - 1);
    assign cols_done = r_j == i_n;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qmgs_pkg::S_IDLE:    if (req_acc) n_state = qmgs_pkg::S_DECODE;
            qmgs_pkg::S_DECODE:  n_state = i_stat.req_is_fact ? qmgs_pkg::S_COL
                                                              : qmgs_pkg::S_RESP;
            qmgs_pkg::S_RESP:    n_state = qmgs_pkg::S_IDLE;
            qmgs_pkg::S_COL: begin
                if (cols_done) begin
                    n_state = qmgs_pkg::S_RESP;
                end else if (r_j == '0) begin
                    n_state = qmgs_pkg::S_NRM_RD;
                end else begin
                    n_state = qmgs_pkg::S_DOT_RD;
                end
            end
            qmgs_pkg::S_DOT_RD:  n_state = qmgs_pkg::S_DOT_MUL;
            qmgs_pkg::S_DOT_MUL: n_state = qmgs_pkg::S_DOT_ACC;
            qmgs_pkg::S_DOT_ACC: n_state = last_k ? qmgs_pkg::S_R_WR : qmgs_pkg::S_DOT_RD;
            qmgs_pkg::S_R_WR:    n_state = qmgs_pkg::S_UPD_RD;
            qmgs_pkg::S_UPD_RD:  n_state = qmgs_pkg::S_UPD_MUL;
            qmgs_pkg::S_UPD_MUL: n_state = qmgs_pkg::S_UPD_WR;
            qmgs_pkg::S_UPD_WR: begin
                if (!last_k) begin
                    n_state = qmgs_pkg::S_UPD_RD;
                end else if (last_i) begin
                    n_state = qmgs_pkg::S_NRM_RD;
                end else begin
                    n_state = qmgs_pkg::S_DOT_RD;
                end
            end
            qmgs_pkg::S_NRM_RD:  n_state = qmgs_pkg::S_NRM_MUL;
            qmgs_pkg::S_NRM_MUL: n_state = qmgs_pkg::S_NRM_ACC;
            qmgs_pkg::S_NRM_ACC: n_state = last_k ? qmgs_pkg::S_SQRT : qmgs_pkg::S_NRM_RD;
            qmgs_pkg::S_SQRT:    if (last_sq) n_state = qmgs_pkg::S_DIAG;
            qmgs_pkg::S_DIAG:    n_state = i_stat.nrm_zero ? qmgs_pkg::S_ZERO_WR
                                                           : qmgs_pkg::S_SCL_RD;
            qmgs_pkg::S_ZERO_WR: if (last_k) n_state = qmgs_pkg::S_COL;
            qmgs_pkg::S_SCL_RD:  n_state = qmgs_pkg::S_DIV_LD;
            qmgs_pkg::S_DIV_LD:  n_state = qmgs_pkg::S_DIV;
            qmgs_pkg::S_DIV:     if (last_div) n_state = qmgs_pkg::S_SCL_WR;
            qmgs_pkg::S_SCL_WR:  n_state = last_k ? qmgs_pkg::S_COL : qmgs_pkg::S_SCL_RD;
            default:             n_state = qmgs_pkg::S_IDLE;
        endcase
    end

    // loop counters
    always_comb begin
        n_k    = r_k;
        n_i    = r_i;
        n_j    = r_j;
        n_step = r_step;
        case (r_state)
            qmgs_pkg::S_DECODE:  n_j = '0;
            qmgs_pkg::S_COL: begin
                n_k    = '0;
                n_i    = '0;
                n_step = '0;
            end
            qmgs_pkg::S_DOT_ACC: n_k = last_k ? '0 : r_k + qmgs_pkg::ROW_CW'(1);
            qmgs_pkg::S_UPD_WR: begin
                if (last_k) begin
                    n_k = '0;
                    if (!last_i) n_i = r_i + qmgs_pkg::COL_CW'(1);
                end else begin
                    n_k = r_k + qmgs_pkg::ROW_CW'(1);
                end
            end
            qmgs_pkg::S_NRM_ACC: n_k = last_k ? '0 : r_k + qmgs_pkg::ROW_CW'(1);
            qmgs_pkg::S_SQRT:    n_step = last_sq ? '0 : r_step + qmgs_pkg::STEP_W'(1);
            qmgs_pkg::S_DIV:     n_step = last_div ? '0 : r_step + qmgs_pkg::STEP_W'(1);
            qmgs_pkg::S_ZERO_WR, qmgs_pkg::S_SCL_WR: begin
                if (last_k) begin
                    n_k = '0;
                    n_j = r_j + qmgs_pkg::COL_CW'(1);
                end else begin
                    n_k = r_k + qmgs_pkg::ROW_CW'(1);
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready = 1'b0;
        o_cmd.op    = qmgs_pkg::OP_NONE;
        o_cmd.k     = r_k;
        o_cmd.i     = r_i;
        o_cmd.j     = r_j;
        o_cmd.first = r_step == '0;
        case (r_state)
            qmgs_pkg::S_IDLE: begin
                o_req_ready = i_stat.out_free;
                if (req_acc) o_cmd.op = qmgs_pkg::OP_LOAD_REQ;
            end
            qmgs_pkg::S_DECODE:  o_cmd.op = i_stat.req_is_fact ? qmgs_pkg::OP_FACT_START
                                                               : qmgs_pkg::OP_ELEM;
            qmgs_pkg::S_RESP:    o_cmd.op = qmgs_pkg::OP_RESP;
            qmgs_pkg::S_DOT_RD:  o_cmd.op = qmgs_pkg::OP_DOT_RD;
            qmgs_pkg::S_DOT_MUL: o_cmd.op = qmgs_pkg::OP_DOT_MUL;
            qmgs_pkg::S_DOT_ACC: o_cmd.op = qmgs_pkg::OP_DOT_ACC;
            qmgs_pkg::S_R_WR:    o_cmd.op = qmgs_pkg::OP_R_WR;
            qmgs_pkg::S_UPD_RD:  o_cmd.op = qmgs_pkg::OP_UPD_RD;
            qmgs_pkg::S_UPD_MUL: o_cmd.op = qmgs_pkg::OP_UPD_MUL;
            qmgs_pkg::S_UPD_WR:  o_cmd.op = qmgs_pkg::OP_UPD_WR;
            qmgs_pkg::S_NRM_RD:  o_cmd.op = qmgs_pkg::OP_NRM_RD;
            qmgs_pkg::S_NRM_MUL: o_cmd.op = qmgs_pkg::OP_NRM_MUL;
            qmgs_pkg::S_NRM_ACC: o_cmd.op = qmgs_pkg::OP_NRM_ACC;
            qmgs_pkg::S_SQRT:    o_cmd.op = qmgs_pkg::OP_SQ_STEP;
            qmgs_pkg::S_DIAG:    o_cmd.op = qmgs_pkg::OP_DIAG_WR;
            qmgs_pkg::S_ZERO_WR: o_cmd.op = qmgs_pkg::OP_ZERO_WR;
            qmgs_pkg::S_SCL_RD:  o_cmd.op = qmgs_pkg::OP_SCL_RD;
            qmgs_pkg::S_DIV_LD:  o_cmd.op = qmgs_pkg::OP_DIV_LD;
            qmgs_pkg::S_DIV:     o_cmd.op = qmgs_pkg::OP_DIV_STEP;
            qmgs_pkg::S_SCL_WR:  o_cmd.op = qmgs_pkg::OP_SCL_WR;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qmgs_pkg::S_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
            r_step  <= n_step;
        end
    end

    a_sqrt_to_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qmgs_pkg::S_SQRT && last_sq) |=> r_state == qmgs_pkg::S_DIAG)
        else $error("square root did not end in the diagonal write");

    a_proj_below_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qmgs_pkg::S_UPD_WR) |-> (r_i < r_j))
        else $error("projection column not below current column");

endmodule

`default_nettype wire

/* hw/rtl/qmgs_dp.sv */
// ----------------------------------------------------------------------------
// QR MGS datapath
// Matrix and R stores, shared multiplier, accumulators, square root, divider
// and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module qmgs_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire qmgs_pkg::t_dp_cmd                   i_cmd,
    output qmgs_pkg::t_dp_stat                       o_stat,
    input  wire logic [qmgs_pkg::ROW_CW-1:0]         i_m,
    input  wire logic [qmgs_pkg::COL_CW-1:0]         i_n,
    input  wire logic [qmgs_pkg::REQ_W-1:0]          i_req_type,
    input  wire logic [qmgs_pkg::IDX_W-1:0]          i_row_index,
    input  wire logic [qmgs_pkg::IDX_W-1:0]          i_col_index,
    input  wire logic signed [qmgs_pkg::ELEM_W-1:0]  i_elem_value,
    output logic                                     o_rsp_valid,
    input  wire logic                                i_rsp_ready,
    output logic signed [qmgs_pkg::ELEM_W-1:0]       o_read_value,
    output logic [qmgs_pkg::STAT_W-1:0]              o_status_code
);

    localparam int AW = qmgs_pkg::MAT_AW;
    localparam int TW = qmgs_pkg::TRI_AW;

    function automatic logic [AW-1:0] mat_addr(input logic [AW-1:0] r, input logic [AW-1:0] c);
        return c * AW'(qmgs_pkg::MAX_ROWS) + r;
    endfunction

    function automatic logic [TW-1:0] tri_addr(input logic [TW-1:0] r, input logic [TW-1:0] c);
        return r * TW'(qmgs_pkg::MAX_COLS) + c;
    endfunction

    // request registers
    qmgs_pkg::t_req                     r_req_type;
    logic [qmgs_pkg::IDX_W-1:0]         r_row, r_col;
    logic signed [qmgs_pkg::ELEM_W-1:0] r_val;
    logic                               r_range_ok;

    // stores
    logic [qmgs_pkg::ELEM_W-1:0]        r_mat [qmgs_pkg::MAT_DEPTH];
    logic [qmgs_pkg::ELEM_W-1:0]        r_tri [qmgs_pkg::TRI_DEPTH];
    logic [qmgs_pkg::TRI_DEPTH-1:0]     r_tri_vld;
    logic signed [qmgs_pkg::ELEM_W-1:0] r_rd_a, r_rd_b, r_tri_q;
    logic                               r_tri_vld_q;

    // arithmetic
    logic signed [63:0]                 r_prod, r_acc;
    logic [63:0]                        r_ss, r_sq_v, r_sq_res, r_sq_bit;
    logic signed [qmgs_pkg::ELEM_W-1:0] r_coef, r_a;
    logic [qmgs_pkg::DIV_STEPS-1:0]     r_dq;
    logic [31:0]                        r_rem;
    logic                               r_neg, r_zflag;

    // response
    logic                               r_out_valid;
    logic signed [qmgs_pkg::ELEM_W-1:0] r_out_value;
    qmgs_pkg::t_status                  r_out_status;

    qmgs_pkg::t_dp_op                   op;
    logic                               range_in, mat_we, mat_re_a, mat_re_b, tri_we;
    logic [AW-1:0]                      mat_wa, mat_ra_a, mat_ra_b, kj_addr;
    logic [TW-1:0]                      tri_wa, tri_ra;
    logic [qmgs_pkg::COL_CW-1:0]        tri_row, tri_col;
    logic signed [qmgs_pkg::ELEM_W-1:0] mat_wd, tri_wd, mul_x, mul_y, q_sat;
    logic signed [qmgs_pkg::ELEM_W-1:0] resp_value;
    qmgs_pkg::t_status                  resp_status;
    logic [31:0]                        nrm, abs_b;
    logic                               nrm_zero;
    logic [63:0]                        sq_v, sq_res, sq_bit, sq_try;
    logic [64:0]                        ss_sum;
    logic [32:0]                        rem_sh, rem_sub;
    logic                               div_ge;

    assign op = i_cmd.op;

    always_comb begin
        if (qmgs_pkg::t_req'(i_req_type) == qmgs_pkg::REQ_RD_R) begin
            range_in = (32'(i_row_index) < 32'(i_n)) && (32'(i_col_index) < 32'(i_n));
        end else begin
            range_in = (32'(i_row_index) < 32'(i_m)) && (32'(i_col_index) < 32'(i_n));
        end
    end

    // store addressing
    assign kj_addr  = mat_addr(AW'(i_cmd.k), AW'(i_cmd.j));
    assign mat_ra_a = mat_addr(AW'(i_cmd.k), AW'(i_cmd.i));
    assign mat_ra_b = (op == qmgs_pkg::OP_ELEM) ? mat_addr(AW'(r_row), AW'(r_col)) : kj_addr;
    assign mat_re_a = (op == qmgs_pkg::OP_DOT_RD) || (op == qmgs_pkg::OP_UPD_RD);
    assign mat_re_b = mat_re_a || (op == qmgs_pkg::OP_NRM_RD) || (op == qmgs_pkg::OP_SCL_RD)
                      || (op == qmgs_pkg::OP_ELEM);
    assign tri_ra   = tri_addr(TW'(r_row), TW'(r_col));

    assign nrm      = r_sq_res[31:0];
    assign nrm_zero = r_sq_res == '0;

    always_comb begin
        if (!r_neg) begin
            q_sat = (r_dq > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : r_dq[31:0];
        end else begin
            q_sat = (r_dq > 48'h0000_8000_0000) ? 32'sh8000_0000 : -r_dq[31:0];
        end
    end

    always_comb begin
        mat_we = 1'b0;
        mat_wa = kj_addr;
        mat_wd = '0;
        case (op)
            qmgs_pkg::OP_ELEM: begin
                mat_we = (r_req_type == qmgs_pkg::REQ_WRITE) && r_range_ok;
                mat_wa = mat_ra_b;
                mat_wd = r_val;
            end
            qmgs_pkg::OP_UPD_WR: begin
                mat_we = 1'b1;
                mat_wd = qmgs_pkg::sat32(64'(r_a) - (r_prod >>> 16));
            end
            qmgs_pkg::OP_ZERO_WR: mat_we = 1'b1;
            qmgs_pkg::OP_SCL_WR: begin
                mat_we = 1'b1;
                mat_wd = q_sat;
            end
            default: ;
        endcase
    end

    always_comb begin
        tri_we  = 1'b0;
        tri_row = i_cmd.j;
        tri_col = i_cmd.j;
        tri_wd  = '0;
        case (op)
            qmgs_pkg::OP_R_WR: begin
                tri_we  = 1'b1;
                tri_row = i_cmd.i;
                tri_wd  = qmgs_pkg::sat32(r_acc);
            end
            qmgs_pkg::OP_DIAG_WR: begin
                tri_we = 1'b1;
                tri_wd = (r_sq_res > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : nrm;
            end
            default: ;
        endcase
    end
    assign tri_wa = tri_addr(TW'(tri_row), TW'(tri_col));

    always_ff @(posedge i_clk) begin
        if (mat_we) r_mat[mat_wa] <= mat_wd;
        if (mat_re_a) r_rd_a <= r_mat[mat_ra_a];
        if (mat_re_b) r_rd_b <= r_mat[mat_ra_b];
        if (tri_we) r_tri[tri_wa] <= tri_wd;
        if (op == qmgs_pkg::OP_ELEM) begin
            r_tri_q     <= r_tri[tri_ra];
            r_tri_vld_q <= r_tri_vld[tri_ra];
        end
    end

    // shared multiplier
    always_comb begin
        mul_x = r_rd_b;
        mul_y = r_rd_b;
        case (op)
            qmgs_pkg::OP_DOT_MUL: mul_x = r_rd_a;
            qmgs_pkg::OP_UPD_MUL: begin
                mul_x = r_rd_a;
                mul_y = r_coef;
            end
            default: ;
        endcase
    end

    // square root: one result bit a cycle
    always_comb begin
        sq_v   = i_cmd.first ? r_ss : r_sq_v;
        sq_res = i_cmd.first ? '0 : r_sq_res;
        sq_bit = i_cmd.first ? 64'h4000_0000_0000_0000 : r_sq_bit;
        sq_try = sq_res + sq_bit;
    end

    assign ss_sum  = {1'b0, r_ss} + {1'b0, r_prod};
    assign abs_b   = r_rd_b[31] ? 32'(-r_rd_b) : 32'(r_rd_b);
    assign rem_sh  = {r_rem, r_dq[qmgs_pkg::DIV_STEPS-1]};
    assign rem_sub = rem_sh - {1'b0, nrm};
    assign div_ge  = rem_sh >= {1'b0, nrm};

    always_ff @(posedge i_clk) begin
        case (op)
            qmgs_pkg::OP_LOAD_REQ: begin
                r_req_type <= qmgs_pkg::t_req'(i_req_type);
                r_row      <= i_row_index;
                r_col      <= i_col_index;
                r_val      <= i_elem_value;
                r_range_ok <= range_in;
            end
            qmgs_pkg::OP_FACT_START: begin
                r_acc <= '0;
                r_ss  <= '0;
            end
            qmgs_pkg::OP_DOT_MUL, qmgs_pkg::OP_NRM_MUL: r_prod <= mul_x * mul_y;
            qmgs_pkg::OP_UPD_MUL: begin
                r_prod <= mul_x * mul_y;
                r_a    <= r_rd_b;
            end
            qmgs_pkg::OP_DOT_ACC: r_acc <= r_acc + (r_prod >>> 16);
            qmgs_pkg::OP_R_WR: begin
                r_coef <= qmgs_pkg::sat32(r_acc);
                r_acc  <= '0;
            end
            qmgs_pkg::OP_NRM_ACC: r_ss <= ss_sum[64] ? '1 : ss_sum[63:0];
            qmgs_pkg::OP_SQ_STEP: begin
                if (sq_v >= sq_try) begin
                    r_sq_v   <= sq_v - sq_try;
                    r_sq_res <= (sq_res >> 1) + sq_bit;
                end else begin
                    r_sq_v   <= sq_v;
                    r_sq_res <= sq_res >> 1;
                end
                r_sq_bit <= sq_bit >> 2;
            end
            qmgs_pkg::OP_DIAG_WR: r_ss <= '0;
            qmgs_pkg::OP_DIV_LD: begin
                r_dq  <= {abs_b, 16'h0000};
                r_rem <= '0;
                r_neg <= r_rd_b[31];
            end
            qmgs_pkg::OP_DIV_STEP: begin
                r_rem <= div_ge ? rem_sub[31:0] : rem_sh[31:0];
                r_dq  <= {r_dq[qmgs_pkg::DIV_STEPS-2:0], div_ge};
            end
            default: ;
        endcase
    end

    // response selection
    always_comb begin
        resp_value = '0;
        case (r_req_type)
            qmgs_pkg::REQ_RD_Q: if (r_range_ok) resp_value = r_rd_b;
            qmgs_pkg::REQ_RD_R: begin
                if (r_range_ok && (r_row <= r_col) && r_tri_vld_q) resp_value = r_tri_q;
            end
            default: ;
        endcase
        if (r_req_type != qmgs_pkg::REQ_FACT && !r_range_ok) begin
            resp_status = qmgs_pkg::ST_RANGE;
        end else begin
            resp_status = r_zflag ? qmgs_pkg::ST_ZERO_NORM : qmgs_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri_vld   <= '0;
            r_zflag     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (op == qmgs_pkg::OP_FACT_START) begin
                r_tri_vld <= '0;
                r_zflag   <= 1'b0;
            end else if (tri_we) begin
                r_tri_vld[tri_wa] <= 1'b1;
            end
            if (op == qmgs_pkg::OP_DIAG_WR && nrm_zero) r_zflag <= 1'b1;
            if (op == qmgs_pkg::OP_RESP) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == qmgs_pkg::OP_RESP) begin
            r_out_value  <= resp_value;
            r_out_status <= resp_status;
        end
    end

    assign o_rsp_valid        = r_out_valid;
    assign o_read_value       = r_out_value;
    assign o_status_code      = r_out_status;
    assign o_stat.out_free    = !r_out_valid || i_rsp_ready;
    assign o_stat.req_is_fact = r_req_type == qmgs_pkg::REQ_FACT;
    assign o_stat.nrm_zero    = nrm_zero;

    a_resp_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == qmgs_pkg::OP_RESP) |-> (!r_out_valid || i_rsp_ready))
        else $error("response written over one not yet taken");

    a_tri_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tri_we |-> (tri_row <= tri_col))
        else $error("R write below the diagonal");

    a_range_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == qmgs_pkg::OP_RESP && !r_range_ok && r_req_type != qmgs_pkg::REQ_FACT)
        |=> (r_out_status == qmgs_pkg::ST_RANGE && r_out_value == '0))
        else $error("out-of-range request not reported");

endmodule

`default_nettype wire

/* hw/rtl/qr_mgs_factorizer_top.sv */
// ----------------------------------------------------------------------------
// QR factoriser (modified Gram-Schmidt), top level
// Stores an m by n Q16.16 matrix, factorises it in place into Q and R on
// request, and reads Q and R elements back by address.
// ----------------------------------------------------------------------------
// Every request returns exactly one response. For element writes and reads
// the accepted request is registered, the store is accessed, and the result
// is then loaded into the response register. A new request is taken once the
// previous one has been answered, so the block never works on two at once.
// A factorise request walks the stored matrix column by column through a
// single shared 32x32 multiplier, a bit-serial square root and a bit-serial
// divider. For each column it runs, for every earlier column in turn, a dot
// product pass, the R write and an update pass over the elements; then the
// norm accumulation, the square root, the diagonal write and one division
// per element, or a zero write per element when the norm is zero. The R
// store needs no clearing pass: each entry has a valid bit, all cleared at
// reset and at the start of every factorise, and an invalid entry reads as
// zero. The matrix store has no reset; reading an element that was never
// written gives an undefined value. Configuration (rows and columns in use)
// must be written by the user only while the block is idle; the block
// itself does not enforce this. Zero acts as one and values above the
// maximum act as the maximum.
`default_nettype none

module qr_mgs_factorizer_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    qmgs_req_if.sink                             i_req,
    qmgs_rsp_if.source                           o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [0:0]                      i_cfg_idx,
    input  wire logic [qmgs_pkg::CFG_W-1:0]      i_cfg_data
);

    // configuration registers, held as written
    logic [qmgs_pkg::CFG_W-1:0]  r_rows, r_cols;
    // effective dimensions after clamping
    logic [qmgs_pkg::ROW_CW-1:0] eff_m;
    logic [qmgs_pkg::COL_CW-1:0] eff_n;

    qmgs_pkg::t_dp_cmd  cmd;
    qmgs_pkg::t_dp_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= qmgs_pkg::CFG_W'(16);
            r_cols <= qmgs_pkg::CFG_W'(16);
        end else if (i_cfg_we) begin
            case (qmgs_pkg::t_cfg_idx'(i_cfg_idx))
                qmgs_pkg::CFG_ROWS: r_rows <= i_cfg_data;
                qmgs_pkg::CFG_COLS: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp: zero acts as one, anything past the store size as the maximum
    always_comb begin
        if (r_rows == '0) begin
            eff_m = qmgs_pkg::ROW_CW'(1);
        end else if (32'(r_rows) > qmgs_pkg::MAX_ROWS) begin
            eff_m = qmgs_pkg::ROW_CW'(qmgs_pkg::MAX_ROWS);
        end else begin
            eff_m = qmgs_pkg::ROW_CW'(r_rows);
        end
        if (r_cols == '0) begin
            eff_n = qmgs_pkg::COL_CW'(1);
        end else if (32'(r_cols) > qmgs_pkg::MAX_COLS) begin
            eff_n = qmgs_pkg::COL_CW'(qmgs_pkg::MAX_COLS);
        end else begin
            eff_n = qmgs_pkg::COL_CW'(r_cols);
        end
    end

    // sequencer: owns the request handshake and all loop counters
    qmgs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_m         (eff_m),
        .i_n         (eff_n),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // stores, arithmetic and the response register
    qmgs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_m           (eff_m),
        .i_n           (eff_n),
        .i_req_type    (i_req.req_type),
        .i_row_index   (i_req.row_index),
        .i_col_index   (i_req.col_index),
        .i_elem_value  (i_req.elem_value),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_read_value  (o_rsp.read_value),
        .o_status_code (o_rsp.status_code)
    );

endmodule

`default_nettype wire
